// ----- hw/rtl/tfc_pkg.sv -----
// types and constants shared by the trigram frequency counter modules
`timescale 1ns / 1ps

package tfc_pkg;

    localparam int KEY_BITS = 48;
    localparam int UNIT_BITS = 16;
    localparam int SLOT_BITS = 12;
    localparam int OUT_COUNT_BITS = 24;
    localparam int USED_BITS = 13;

    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_EOL   = 2'd1,
        KIND_READ  = 2'd2,
        KIND_CLEAR = 2'd3
    } tfc_kind_t;

    typedef enum logic [1:0] {
        STATUS_COUNTED    = 2'd0,
        STATUS_DROPPED    = 2'd1,
        STATUS_READ_VALID = 2'd2,
        STATUS_READ_EMPTY = 2'd3
    } tfc_status_t;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2
    } tfc_op_t;

    typedef struct packed {
        tfc_kind_t              kind;
        logic [UNIT_BITS-1:0]   code_unit;
        logic [SLOT_BITS-1:0]   slot_index;
    } tfc_item_t;

    typedef struct packed {
        tfc_status_t                status;
        logic [KEY_BITS-1:0]        trigram_key;
        logic [OUT_COUNT_BITS-1:0]  trigram_count;
        logic [SLOT_BITS-1:0]       slot_number;
        logic [USED_BITS-1:0]       entries_used;
    } tfc_result_t;

    typedef struct packed {
        tfc_op_t                op;
        logic [KEY_BITS-1:0]    key;
        logic [SLOT_BITS-1:0]   slot;
    } tfc_req_t;

endpackage

// ----- hw/rtl/tfc_table.sv -----
// trigram table: key and count memories with a sequential scan engine
`timescale 1ns / 1ps

module tfc_table #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int COUNT_BITS = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  tfc_pkg::tfc_req_t    req,
    output logic                 idle,
    output logic                 res_valid,
    output tfc_pkg::tfc_result_t res,
    input  logic                 res_take
);
    import tfc_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int UW = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_READ = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [UW-1:0] used_reg, used_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [SLOT_BITS-1:0] slot_reg, slot_next;
    tfc_result_t res_reg, res_next;

    logic [KEY_BITS-1:0] key_mem [TABLE_ENTRIES];
    logic [COUNT_BITS-1:0] count_mem [TABLE_ENTRIES];
    logic [KEY_BITS-1:0] rd_key_reg;
    logic [COUNT_BITS-1:0] rd_cnt_reg;
    logic [IW-1:0] addr, addr_reg;

    logic key_we, cnt_we;
    logic [IW-1:0] waddr;
    logic [KEY_BITS-1:0] wkey;
    logic [COUNT_BITS-1:0] wcnt;

    always_ff @(posedge clk)
    begin
        rd_key_reg <= key_mem[addr];
        rd_cnt_reg <= count_mem[addr];
        addr_reg <= addr;
        if (key_we)
        begin
            key_mem[waddr] <= wkey;
        end
        if (cnt_we)
        begin
            count_mem[waddr] <= wcnt;
        end
    end

    always_comb
    begin
        logic [31:0] slot_ext;
        logic [31:0] addr_ext;
        logic [31:0] used_ext;
        logic [31:0] cnt_ext;
        logic [31:0] used_inc;
        logic [COUNT_BITS-1:0] cnt_inc;

        state_next = state_reg;
        used_next = used_reg;
        key_next = key_reg;
        slot_next = slot_reg;
        res_next = res_reg;
        addr = addr_reg + IW'(1);
        key_we = 1'b0;
        cnt_we = 1'b0;
        waddr = used_reg[IW-1:0];
        wkey = key_reg;
        wcnt = COUNT_BITS'(1);

        slot_ext = 32'(req.slot);
        addr_ext = 32'(addr_reg);
        used_ext = 32'(used_reg);
        used_inc = used_ext + 32'd1;
        cnt_ext = 32'(rd_cnt_reg);
        cnt_inc = (rd_cnt_reg == {COUNT_BITS{1'b1}}) ? rd_cnt_reg : rd_cnt_reg + COUNT_BITS'(1);

        unique case (state_reg)
            ST_IDLE:
            begin
                addr = '0;
                if (req_valid)
                begin
                    unique case (req.op)
                        OP_LOOKUP:
                        begin
                            key_next = req.key;
                            if (used_reg == '0)
                            begin
                                key_we = 1'b1;
                                cnt_we = 1'b1;
                                waddr = '0;
                                wkey = req.key;
                                used_next = UW'(1);
                                res_next.status = STATUS_COUNTED;
                                res_next.trigram_key = req.key;
                                res_next.trigram_count = OUT_COUNT_BITS'(1);
                                res_next.slot_number = '0;
                                res_next.entries_used = USED_BITS'(1);
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        OP_READ:
                        begin
                            slot_next = req.slot;
                            if (slot_ext < used_ext)
                            begin
                                addr = slot_ext[IW-1:0];
                                state_next = ST_READ;
                            end
                            else
                            begin
                                res_next.status = STATUS_READ_EMPTY;
                                res_next.trigram_key = '0;
                                res_next.trigram_count = '0;
                                res_next.slot_number = req.slot;
                                res_next.entries_used = used_ext[USED_BITS-1:0];
                                state_next = ST_DONE;
                            end
                        end
                        OP_CLEAR:
                        begin
                            used_next = '0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (rd_key_reg == key_reg)
                begin
                    cnt_we = 1'b1;
                    waddr = addr_reg;
                    wcnt = cnt_inc;
                    cnt_ext = 32'(cnt_inc);
                    res_next.status = STATUS_COUNTED;
                    res_next.trigram_key = key_reg;
                    res_next.trigram_count = cnt_ext[OUT_COUNT_BITS-1:0];
                    res_next.slot_number = addr_ext[SLOT_BITS-1:0];
                    res_next.entries_used = used_ext[USED_BITS-1:0];
                    state_next = ST_DONE;
                end
                else if (addr_ext + 32'd1 == used_ext)
                begin
                    if (used_ext == 32'(TABLE_ENTRIES))
                    begin
                        res_next.status = STATUS_DROPPED;
                        res_next.trigram_key = key_reg;
                        res_next.trigram_count = '0;
                        res_next.slot_number = '0;
                        res_next.entries_used = used_ext[USED_BITS-1:0];
                    end
                    else
                    begin
                        key_we = 1'b1;
                        cnt_we = 1'b1;
                        used_next = used_inc[UW-1:0];
                        res_next.status = STATUS_COUNTED;
                        res_next.trigram_key = key_reg;
                        res_next.trigram_count = OUT_COUNT_BITS'(1);
                        res_next.slot_number = used_ext[SLOT_BITS-1:0];
                        res_next.entries_used = used_inc[USED_BITS-1:0];
                    end
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                res_next.status = STATUS_READ_VALID;
                res_next.trigram_key = rd_key_reg;
                res_next.trigram_count = cnt_ext[OUT_COUNT_BITS-1:0];
                res_next.slot_number = slot_reg;
                res_next.entries_used = used_ext[USED_BITS-1:0];
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            used_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        slot_reg <= slot_next;
        res_reg <= res_next;
    end

    assign idle = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res = res_reg;

endmodule

// ----- hw/rtl/trigram_frequency_counter.sv -----
// trigram frequency counter top level: line tracking, table engine and result register
//
// An item is taken only while the table engine is idle. End-of-line, clear and characters
// that form no nonzero trigram leave the engine idle. A read of a used slot passes through
// the read state to the done state. A trigram lookup scans the key memory one slot per
// cycle in first-seen order, through the single read port of the key memory. A finished
// result waits in the output register while the next item is taken.
`timescale 1ns / 1ps

module trigram_frequency_counter #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int COUNT_BITS = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  tfc_pkg::tfc_item_t   item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output tfc_pkg::tfc_result_t result
);
    import tfc_pkg::*;

    logic [UNIT_BITS-1:0] older_reg, older_next;
    logic [UNIT_BITS-1:0] newer_reg, newer_next;
    logic [1:0] units_reg, units_next;
    logic out_valid_reg, out_valid_next;
    tfc_result_t out_reg;

    logic eng_idle, eng_res_valid, eng_take, accept, req_valid;
    tfc_req_t req;
    tfc_result_t eng_res;

    assign item_stall = !eng_idle;
    assign accept = item_valid && eng_idle;

    always_comb
    begin
        logic [KEY_BITS-1:0] key;
        key = {older_reg, newer_reg, item.code_unit};
        older_next = older_reg;
        newer_next = newer_reg;
        units_next = units_reg;
        req_valid = 1'b0;
        req.op = OP_LOOKUP;
        req.key = key;
        req.slot = item.slot_index;
        if (accept)
        begin
            unique case (item.kind)
                KIND_CHAR:
                begin
                    if (units_reg == 2'd2)
                    begin
                        req_valid = (key != '0);
                    end
                    else
                    begin
                        units_next = units_reg + 2'd1;
                    end
                    older_next = newer_reg;
                    newer_next = item.code_unit;
                end
                KIND_EOL:
                begin
                    older_next = '0;
                    newer_next = '0;
                    units_next = '0;
                end
                KIND_READ:
                begin
                    req_valid = 1'b1;
                    req.op = OP_READ;
                end
                KIND_CLEAR:
                begin
                    req_valid = 1'b1;
                    req.op = OP_CLEAR;
                end
                default:
                begin
                    req_valid = 1'b0;
                end
            endcase
        end
    end

    tfc_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .COUNT_BITS(COUNT_BITS)
    ) u_table (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req(req),
        .idle(eng_idle),
        .res_valid(eng_res_valid),
        .res(eng_res),
        .res_take(eng_take)
    );

    assign eng_take = eng_res_valid && (!out_valid_reg || !result_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (eng_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_reg <= '0;
            newer_reg <= '0;
            units_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            older_reg <= older_next;
            newer_reg <= newer_next;
            units_reg <= units_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_take)
        begin
            out_reg <= eng_res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result = out_reg;

endmodule

// ----- tb/trigram_frequency_counter_test.sv -----
// self-checking testbench for the trigram frequency counter with a built-in trigram table predictor
`timescale 1ns / 1ps

module trigram_frequency_counter_test;

    import tfc_pkg::*;

    localparam int TABLE_SIZE = 4096;
    localparam int CNT_BITS = 24;
    localparam logic [OUT_COUNT_BITS-1:0] CNT_MAX = OUT_COUNT_BITS'((1 << CNT_BITS) - 1);
    localparam int CYCLE_LIMIT = 4000000;
    localparam int SETTLE_CYCLES = TABLE_SIZE + 16;
    localparam int REPEAT_CHARS = 40;
    localparam int FILL_CHARS = 80;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    tfc_item_t   item;
    logic        result_valid;
    logic        result_stall;
    tfc_result_t result;

    logic [UNIT_BITS-1:0]      line_older;
    logic [UNIT_BITS-1:0]      line_newer;
    int unsigned               line_units;
    logic [KEY_BITS-1:0]       trigram_keys [TABLE_SIZE];
    logic [OUT_COUNT_BITS-1:0] trigram_counts [TABLE_SIZE];
    int unsigned               table_used;
    tfc_result_t               pending_results [$];

    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned drops_seen;
    int unsigned reads_seen;
    int unsigned saturations_seen;
    bit          no_gaps;
    bit          receiver_busy;

    trigram_frequency_counter #(
        .TABLE_ENTRIES(TABLE_SIZE),
        .COUNT_BITS(CNT_BITS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // receiver stall pattern
    initial
    begin
        int unsigned hold;
        result_stall = 1'b0;
        receiver_busy = 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
                hold--;
            else
            begin
                hold = receiver_busy ? pick_gap() : 0;
                result_stall <= (hold > 0) && receiver_busy;
            end
        end
    end

    task automatic model_trigram(input logic [KEY_BITS-1:0] key);
        tfc_result_t r;
        int unsigned i;
        bit          found;
        found = 0;
        r = '0;
        r.trigram_key = key;
        for (i = 0; i < table_used; i++)
        begin
            if (!found && trigram_keys[i] == key)
            begin
                found = 1;
                if (trigram_counts[i] < CNT_MAX)
                    trigram_counts[i]++;
                r.status = STATUS_COUNTED;
                r.trigram_count = trigram_counts[i];
                r.slot_number = SLOT_BITS'(i);
            end
        end
        if (!found && table_used >= TABLE_SIZE)
        begin
            r.status = STATUS_DROPPED;
        end
        else if (!found)
        begin
            trigram_keys[table_used] = key;
            trigram_counts[table_used] = OUT_COUNT_BITS'(1);
            r.status = STATUS_COUNTED;
            r.trigram_count = OUT_COUNT_BITS'(1);
            r.slot_number = SLOT_BITS'(table_used);
            table_used++;
        end
        r.entries_used = USED_BITS'(table_used);
        pending_results.push_back(r);
    endtask

    task automatic model_item(input tfc_item_t it);
        tfc_result_t r;
        logic [KEY_BITS-1:0] key;
        r = '0;
        case (it.kind)
            KIND_CHAR:
            begin
                if (line_units >= 2)
                begin
                    key = {line_older, line_newer, it.code_unit};
                    if (key != '0)
                        model_trigram(key);
                end
                else
                    line_units++;
                line_older = line_newer;
                line_newer = it.code_unit;
            end
            KIND_EOL:
            begin
                line_older = '0;
                line_newer = '0;
                line_units = 0;
            end
            KIND_READ:
            begin
                r.slot_number = it.slot_index;
                r.entries_used = USED_BITS'(table_used);
                if (32'(it.slot_index) < table_used)
                begin
                    r.status = STATUS_READ_VALID;
                    r.trigram_key = trigram_keys[it.slot_index];
                    r.trigram_count = trigram_counts[it.slot_index];
                end
                else
                    r.status = STATUS_READ_EMPTY;
                pending_results.push_back(r);
            end
            KIND_CLEAR:
                table_used = 0;
        endcase
    endtask

    always @(posedge clk)
    begin
        tfc_result_t exp_r;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected transaction: status %0d key %h", result.status,
                       result.trigram_key);
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (exp_r.status == STATUS_DROPPED)
                    drops_seen++;
                if (exp_r.status == STATUS_READ_VALID)
                    reads_seen++;
                if (exp_r.status == STATUS_COUNTED && exp_r.trigram_count == CNT_MAX)
                    saturations_seen++;
                if (result.status !== exp_r.status)
                begin
                    $error("status: expected %0d actual %0d", exp_r.status, result.status);
                    error_count++;
                end
                if (result.trigram_key !== exp_r.trigram_key)
                begin
                    $error("trigram_key: expected %h actual %h", exp_r.trigram_key,
                           result.trigram_key);
                    error_count++;
                end
                if (result.trigram_count !== exp_r.trigram_count)
                begin
                    $error("trigram_count: expected %0d actual %0d", exp_r.trigram_count,
                           result.trigram_count);
                    error_count++;
                end
                if (result.slot_number !== exp_r.slot_number)
                begin
                    $error("slot_number: expected %0d actual %0d", exp_r.slot_number,
                           result.slot_number);
                    error_count++;
                end
                if (result.entries_used !== exp_r.entries_used)
                begin
                    $error("entries_used: expected %0d actual %0d", exp_r.entries_used,
                           result.entries_used);
                    error_count++;
                end
            end
        end
    end

    task automatic send_item(input tfc_kind_t kind, input logic [UNIT_BITS-1:0] unit,
                             input logic [SLOT_BITS-1:0] slot);
        tfc_item_t   it;
        int unsigned gap;
        it.kind = kind;
        it.code_unit = unit;
        it.slot_index = slot;
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        model_item(it);
        items_sent++;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_char(input logic [UNIT_BITS-1:0] unit);
        send_item(KIND_CHAR, unit, SLOT_BITS'($urandom_range(0, 4095)));
    endtask

    task automatic wait_for_results();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        send_char(16'h0041);
        send_char(16'h0042);
        send_item(KIND_EOL, UNIT_BITS'($urandom), SLOT_BITS'($urandom));
        send_char(16'h0000);
        send_char(16'h0000);
        send_char(16'h0000);
        send_char(16'hFFFF);
        send_char(16'hFFFF);
        send_char(16'hFFFF);
        send_char(16'h8000);
        send_char(16'h0001);
        send_item(KIND_EOL, 16'hFFFF, 12'hFFF);
        send_char(16'hFFFF);
        send_char(16'hFFFF);
        send_char(16'hFFFF);
        send_item(KIND_READ, 16'h0000, 12'd0);
        send_item(KIND_READ, 16'hFFFF, 12'd2);
        send_item(KIND_READ, 16'h0000, 12'd3);
        send_item(KIND_READ, 16'h0000, 12'hFFF);
        send_item(KIND_CLEAR, 16'hFFFF, 12'hFFF);
        send_item(KIND_READ, 16'h0000, 12'd0);
        send_char(16'h0002);
        send_item(KIND_EOL, 16'h0000, 12'h000);
    endtask

    task automatic test_repeated_trigram();
        int i;
        send_item(KIND_CLEAR, UNIT_BITS'($urandom), SLOT_BITS'($urandom));
        for (i = 0; i < REPEAT_CHARS; i++)
            send_char(16'h0061);
        send_item(KIND_EOL, UNIT_BITS'($urandom), SLOT_BITS'($urandom));
        send_item(KIND_READ, UNIT_BITS'($urandom), 12'd0);
    endtask

    task automatic test_table_growth();
        int i;
        send_item(KIND_CLEAR, UNIT_BITS'($urandom), SLOT_BITS'($urandom));
        for (i = 0; i < FILL_CHARS; i++)
            send_char(UNIT_BITS'($urandom));
        send_item(KIND_EOL, UNIT_BITS'($urandom), SLOT_BITS'($urandom));
        for (i = 0; i < FILL_CHARS; i++)
            send_item(KIND_READ, UNIT_BITS'($urandom), SLOT_BITS'(i));
    endtask

    task automatic test_random_text(input int unsigned count);
        int unsigned i;
        int unsigned r;
        logic [UNIT_BITS-1:0] unit;
        for (i = 0; i < count; i++)
        begin
            if (i % 200 == 100)
                no_gaps = ~no_gaps;
            r = $urandom_range(0, 99);
            if (r < 72)
            begin
                if ($urandom_range(0, 3) != 0)
                    unit = 16'h0061 + UNIT_BITS'($urandom_range(0, 5));
                else
                    unit = UNIT_BITS'($urandom);
                send_char(unit);
            end
            else if (r < 84)
                send_item(KIND_EOL, UNIT_BITS'($urandom), SLOT_BITS'($urandom));
            else if (r < 97)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_item(KIND_READ, UNIT_BITS'($urandom), SLOT_BITS'($urandom));
                else
                    send_item(KIND_READ, UNIT_BITS'($urandom),
                              SLOT_BITS'($urandom_range(0, 40)));
            end
            else
                send_item(KIND_CLEAR, UNIT_BITS'($urandom), SLOT_BITS'($urandom));
        end
        no_gaps = 0;
    endtask

    task automatic test_pause_until_drained();
        int i;
        for (i = 0; i < 6; i++)
            send_char(16'h0061 + UNIT_BITS'(i));
        item_valid <= 1'b0;
        wait_for_results();
        for (i = 0; i < 4; i++)
            send_item(KIND_READ, UNIT_BITS'($urandom), SLOT_BITS'(i));
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        error_count = 0;
        cycle_count = 0;
        items_sent = 0;
        results_seen = 0;
        drops_seen = 0;
        reads_seen = 0;
        saturations_seen = 0;
        no_gaps = 0;
        line_older = '0;
        line_newer = '0;
        line_units = 0;
        table_used = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_repeated_trigram();
        test_pause_until_drained();
        test_table_growth();
        test_random_text(800);
        item_valid <= 1'b0;
        wait_for_results();
        receiver_busy = 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("sent %0d items, checked %0d results", items_sent, results_seen);
        $display("table-full drops %0d, valid reads %0d, saturated counts %0d",
                 drops_seen, reads_seen, saturations_seen);
        if (error_count == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
